/* sv/oaids_pkg.sv */
// Shared types and constants for the ordered array block.
package oaids_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_DUMP   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_BAD_POS   = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_ROTATE = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type             cmd;
      logic [IDX_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_SCAN = 1'b1
   } fsm_type;

endpackage

/* sv/oaids_cell.sv */
// One storage cell of the entry ring: hold, shift up, shift down or rotate.
module oaids_cell import oaids_pkg::*; (
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic [IDX_W-1:0]         cell_idx,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   output logic signed [DATA_W-1:0] data_out
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.cmd)
         CMD_INSERT: begin
            if (cell_idx == ctl.pos) begin
               data_in = ctl.value;
            end else if (cell_idx > ctl.pos) begin
               data_in = left_data;
            end
         end
         CMD_DELETE: begin
            if (cell_idx >= ctl.pos) begin
               data_in = right_data;
            end
         end
         CMD_ROTATE: begin
            data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

/* sv/ordered_array_insert_delete_search.sv */
// Top level: command decode, scan sequencer and ring of entry cells.
// Insert, delete, and any command on an empty array: one result in the cycle after
// the word is accepted; busy stays low, so a new word may follow every cycle.
// Search and dump on a non-empty array: busy while the cell ring makes one full
// rotation; dump results leave in index order.
// Synchronous active-high reset empties the array; results are never stalled.
module ordered_array_insert_delete_search import oaids_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_opcode,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [CNT_W-1:0]         req_position,
   output logic                     rsp_valid,
   output logic [2:0]               rsp_status,
   output logic [IDX_W-1:0]         rsp_index,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic [CNT_W-1:0]         rsp_entry_count,
   output logic                     rsp_last
);

   fsm_type                  state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         step_ff, step_in;
   opcode_type               op_ff, op_in;
   logic signed [DATA_W-1:0] target_ff, target_in;
   logic                     found_ff, found_in;

   logic                     valid_ff, valid_in;
   status_type               status_ff, status_in;
   logic [IDX_W-1:0]         index_ff, index_in;
   logic signed [DATA_W-1:0] element_ff, element_in;
   logic [CNT_W-1:0]         ecount_ff, ecount_in;
   logic                     last_ff, last_in;

   cell_ctl_type             ctl;
   logic signed [DATA_W-1:0] cell_data [DEPTH];
   opcode_type               req_op;
   logic                     step_live;
   logic                     step_final;

   assign req_op     = opcode_type'(req_opcode);
   assign step_live  = {1'b0, step_ff} < count_ff;
   assign step_final = {1'b0, step_ff} == (count_ff - CNT_W'(1));

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      step_in    = step_ff;
      op_in      = op_ff;
      target_in  = target_ff;
      found_in   = found_ff;
      valid_in   = 1'b0;
      status_in  = STATUS_OK;
      index_in   = '0;
      element_in = '0;
      ecount_in  = count_ff;
      last_in    = 1'b1;
      ctl.cmd    = CMD_HOLD;
      ctl.pos    = req_position[IDX_W-1:0];
      ctl.value  = req_value;

      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               valid_in = 1'b1;
               case (req_op)
                  OP_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else if (req_position > count_ff) begin
                        status_in = STATUS_BAD_POS;
                     end else begin
                        ctl.cmd   = CMD_INSERT;
                        count_in  = count_ff + CNT_W'(1);
                        ecount_in = count_in;
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else if (req_position >= count_ff) begin
                        status_in = STATUS_BAD_POS;
                     end else begin
                        ctl.cmd   = CMD_DELETE;
                        count_in  = count_ff - CNT_W'(1);
                        ecount_in = count_in;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        valid_in  = 1'b0;
                        state_in  = FSM_SCAN;
                        step_in   = '0;
                        op_in     = req_op;
                        target_in = req_value;
                        found_in  = 1'b0;
                     end
                  end
               endcase
            end
         end
         FSM_SCAN: begin
            ctl.cmd = CMD_ROTATE;
            step_in = step_ff + IDX_W'(1);
            if (step_live) begin
               if (op_ff == OP_DUMP) begin
                  valid_in   = 1'b1;
                  index_in   = step_ff;
                  element_in = cell_data[0];
                  last_in    = step_final;
               end else if (!found_ff) begin
                  if (cell_data[0] == target_ff) begin
                     valid_in = 1'b1;
                     index_in = step_ff;
                     found_in = 1'b1;
                  end else if (step_final) begin
                     valid_in  = 1'b1;
                     status_in = STATUS_NOT_FOUND;
                  end
               end
            end
            if (step_ff == IDX_W'(DEPTH - 1)) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      op_ff      <= op_in;
      target_ff  <= target_in;
      found_ff   <= found_in;
      status_ff  <= status_in;
      index_ff   <= index_in;
      element_ff <= element_in;
      ecount_ff  <= ecount_in;
      last_ff    <= last_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      oaids_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_idx   (IDX_W'(i)),
         .left_data  (cell_data[(i + DEPTH - 1) % DEPTH]),
         .right_data (cell_data[(i + 1) % DEPTH]),
         .data_out   (cell_data[i])
      );
   end

   assign busy            = (state_ff != FSM_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_index       = index_ff;
   assign rsp_element     = element_ff;
   assign rsp_entry_count = ecount_ff;
   assign rsp_last        = last_ff;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ordered array block: shadow array, directed and random words.
module testbench;
   import oaids_pkg::*;

   localparam int QUIET_LIMIT = 1000;

   typedef struct {
      status_type               status;
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] element;
      logic [CNT_W-1:0]         entry_count;
      logic                     fin;
   } result_word_type;

   class array_tracker;
      logic signed [DATA_W-1:0] shadow_entries[DEPTH];
      int                       shadow_count = 0;
      result_word_type          pending_results[$];
      int                       errors = 0;

      function void push_result(status_type st, int idx, logic signed [DATA_W-1:0] elem,
                                logic fin);
         result_word_type r;
         r.status      = st;
         r.index       = IDX_W'(idx);
         r.element     = elem;
         r.entry_count = CNT_W'(shadow_count);
         r.fin         = fin;
         pending_results.push_back(r);
      endfunction

      function void note_word(opcode_type op, logic signed [DATA_W-1:0] val, int pos);
         int i;
         int hit;
         case (op)
            OP_INSERT: begin
               if (shadow_count >= DEPTH) begin
                  push_result(STATUS_FULL, 0, 0, 1'b1);
               end else if (pos > shadow_count) begin
                  push_result(STATUS_BAD_POS, 0, 0, 1'b1);
               end else begin
                  for (i = shadow_count; i > pos; i--)
                     shadow_entries[i] = shadow_entries[i-1];
                  shadow_entries[pos] = val;
                  shadow_count++;
                  push_result(STATUS_OK, 0, 0, 1'b1);
               end
            end
            OP_DELETE: begin
               if (shadow_count == 0) begin
                  push_result(STATUS_EMPTY, 0, 0, 1'b1);
               end else if (pos >= shadow_count) begin
                  push_result(STATUS_BAD_POS, 0, 0, 1'b1);
               end else begin
                  for (i = pos; i + 1 < shadow_count; i++)
                     shadow_entries[i] = shadow_entries[i+1];
                  shadow_count--;
                  push_result(STATUS_OK, 0, 0, 1'b1);
               end
            end
            OP_SEARCH: begin
               hit = -1;
               for (i = 0; i < shadow_count; i++)
                  if (hit < 0 && shadow_entries[i] == val) hit = i;
               if (shadow_count == 0) push_result(STATUS_EMPTY, 0, 0, 1'b1);
               else if (hit < 0) push_result(STATUS_NOT_FOUND, 0, 0, 1'b1);
               else push_result(STATUS_OK, hit, 0, 1'b1);
            end
            default: begin
               if (shadow_count == 0) begin
                  push_result(STATUS_EMPTY, 0, 0, 1'b1);
               end else begin
                  for (i = 0; i < shadow_count; i++)
                     push_result(STATUS_OK, i, shadow_entries[i], i + 1 == shadow_count);
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [2:0] st, logic [IDX_W-1:0] idx,
                                 logic signed [DATA_W-1:0] elem, logic [CNT_W-1:0] cnt,
                                 logic fin);
         result_word_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual status %0d index %0d %s %0d",
                     $time, st, idx, "element", elem);
            errors++;
         end else begin
            want = pending_results.pop_front();
            compare_field("status", want.status, st);
            compare_field("index", want.index, idx);
            compare_field("element", want.element, elem);
            compare_field("entry_count", want.entry_count, cnt);
            compare_field("last", want.fin, fin);
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_opcode;
   logic signed [DATA_W-1:0] req_value;
   logic [CNT_W-1:0]         req_position;
   logic                     rsp_valid;
   logic [2:0]               rsp_status;
   logic [IDX_W-1:0]         rsp_index;
   logic signed [DATA_W-1:0] rsp_element;
   logic [CNT_W-1:0]         rsp_entry_count;
   logic                     rsp_last;

   array_tracker tracker;
   int           idle_pct = 19;

   ordered_array_insert_delete_search i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_index       (rsp_index),
      .rsp_element     (rsp_element),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            tracker.check_result(rsp_status, rsp_index, rsp_element, rsp_entry_count, rsp_last);
         if (start && !busy)
            tracker.note_word(opcode_type'(req_opcode), req_value, req_position);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || rsp_valid || (start && !busy)) quiet = 0;
         else quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   task automatic send_word(opcode_type op, logic signed [DATA_W-1:0] val, int pos);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start        <= 1'b1;
      req_opcode   <= op;
      req_value    <= val;
      req_position <= CNT_W'(pos);
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 25 && tracker.shadow_count > 0)
         return tracker.shadow_entries[$urandom_range(tracker.shadow_count - 1)];
      if (r < 50) return $signed($urandom_range(7)) - 4;
      return $urandom;
   endfunction

   function automatic int pick_position(opcode_type op);
      int valid_top;
      valid_top = (op == OP_INSERT) ? tracker.shadow_count : tracker.shadow_count - 1;
      if (valid_top >= 0 && $urandom_range(99) < 85) return $urandom_range(valid_top);
      if (valid_top + 1 <= DEPTH) return $urandom_range(DEPTH, valid_top + 1);
      return $urandom_range(DEPTH);
   endfunction

   task automatic random_mixed(int n, int w_ins, int w_del, int w_srch);
      int k;
      int r;
      opcode_type op;
      for (k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < w_ins) op = OP_INSERT;
         else if (r < w_ins + w_del) op = OP_DELETE;
         else if (r < w_ins + w_del + w_srch) op = OP_SEARCH;
         else op = OP_DUMP;
         send_word(op, pick_value(), pick_position(op));
      end
   endtask

   initial begin
      tracker      = new;
      reset        = 1'b1;
      start        = 1'b0;
      req_opcode   = OP_INSERT;
      req_value    = '0;
      req_position = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(OP_DUMP, 0, 0);
      send_word(OP_SEARCH, 0, 0);
      send_word(OP_DELETE, 0, 0);
      send_word(OP_INSERT, 7, 1);
      send_word(OP_INSERT, 32'sh80000000, 0);
      send_word(OP_INSERT, 32'sh7fffffff, 1);
      send_word(OP_INSERT, 0, 0);
      send_word(OP_INSERT, 5, DEPTH);
      send_word(OP_INSERT, -1, 1);
      send_word(OP_INSERT, -1, 4);
      send_word(OP_SEARCH, -1, 0);
      send_word(OP_SEARCH, 32'sh7fffffff, 0);
      send_word(OP_SEARCH, 12345, 0);
      send_word(OP_DUMP, 0, 0);
      send_word(OP_DELETE, 0, 5);
      send_word(OP_DELETE, 0, DEPTH);
      send_word(OP_DELETE, 0, 4);
      send_word(OP_DELETE, 0, 0);
      send_word(OP_DELETE, 0, 1);
      send_word(OP_DUMP, 0, 0);
      send_word(OP_DELETE, 0, 0);
      send_word(OP_DELETE, 0, 0);
      send_word(OP_DUMP, 0, 0);

      random_mixed(40, 50, 20, 20);
      drain_results();

      // hold start high back to back until the array fills
      idle_pct = 0;
      while (tracker.shadow_count < DEPTH)
         send_word(OP_INSERT, pick_value(), $urandom_range(tracker.shadow_count));
      idle_pct = 19;
      send_word(OP_INSERT, pick_value(), DEPTH);
      send_word(OP_INSERT, pick_value(), 0);
      send_word(OP_SEARCH, tracker.shadow_entries[DEPTH-1], 0);
      send_word(OP_SEARCH, pick_value(), 0);
      send_word(OP_DUMP, 0, 0);
      send_word(OP_DELETE, 0, DEPTH);
      send_word(OP_DELETE, 0, DEPTH - 1);

      random_mixed(40, 20, 50, 20);
      drain_results();
      repeat (DEPTH + 8) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
